// ===== sv/escaped_frame_transmitter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escaped frame transmitter
// Clocked on clk, disabled while arst_n is low; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`define ESCAPED_FRAME_TRANSMITTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define EFT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define EFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define EFT_ASSERT_IMPL(lbl, ante, cons)
`define EFT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/eft_pkg.sv =====
// ----------------------------------------------------------------------------
// eft_pkg
// Shared constants and the command type passed from front to back.
// ----------------------------------------------------------------------------
package eft_pkg;

	localparam logic [7:0] START_BYTE  = 8'hF0;
	localparam logic [7:0] ESCAPE_BYTE = 8'hF1;
	localparam logic [7:0] END_BYTE    = 8'hF7;

	// command queue depth
	localparam int unsigned CMD_DEPTH = 2;
	localparam int unsigned CMD_AW    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int unsigned CMD_CW    = $clog2(CMD_DEPTH + 1);

	// bit positions in the byte schedule of one command
	localparam int unsigned SEL_START = 0;
	localparam int unsigned SEL_ESC   = 1;
	localparam int unsigned SEL_DATA  = 2;
	localparam int unsigned SEL_CHK   = 3;
	localparam int unsigned SEL_END   = 4;
	localparam int unsigned SEL_N     = 5;

	typedef logic [SEL_N-1:0] sel_mask_t;

	// one classified input item
	typedef struct packed {
		sel_mask_t  mask;  // line bytes still to send, lowest bit first
		logic [7:0] data;  // payload byte, already inverted if escaped
	} cmd_t;

endpackage

// ===== sv/eft_front.sv =====
// ----------------------------------------------------------------------------
// eft_front
// Accepts payload items and turns each into a byte schedule command.
// ----------------------------------------------------------------------------
module eft_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [7:0]   payload_byte,
	input  logic         last_byte,
	input  logic         empty_packet,
	input  logic         q_full,
	output logic         in_ready,
	output logic         push,
	output eft_pkg::cmd_t push_cmd
);
	import eft_pkg::*;

	logic in_frame_q;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// classify the item
	always_comb begin
		push_cmd.mask            = '0;
		push_cmd.mask[SEL_START] = !in_frame_q;
		if (empty_packet) begin
			push_cmd.mask[SEL_CHK] = 1'b1;
			push_cmd.mask[SEL_END] = 1'b1;
			push_cmd.data          = 8'h00;
		end else begin
			push_cmd.mask[SEL_ESC]  = payload_byte[7];
			push_cmd.mask[SEL_DATA] = 1'b1;
			push_cmd.mask[SEL_CHK]  = last_byte;
			push_cmd.mask[SEL_END]  = last_byte;
			push_cmd.data           = payload_byte[7] ? ~payload_byte : payload_byte;
		end
	end

	// frame open tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (push) begin
			in_frame_q <= !(empty_packet || last_byte);
		end
	end

endmodule

// ===== sv/eft_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// eft_cmd_fifo
// Small register queue of commands between front and back.
// ----------------------------------------------------------------------------
module eft_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  eft_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output eft_pkg::cmd_t pop_cmd
);
	import eft_pkg::*;

	cmd_t              entry_q [CMD_DEPTH];
	logic [CMD_AW-1:0] wr_ptr_q;
	logic [CMD_AW-1:0] rd_ptr_q;
	logic [CMD_CW-1:0] count_q;

	assign full      = (count_q == CMD_CW'(CMD_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMD_AW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMD_AW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/eft_back.sv =====
// ----------------------------------------------------------------------------
// eft_back
// Walks each command's byte schedule, keeps the checksum, drives the output.
// ----------------------------------------------------------------------------
module eft_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  eft_pkg::cmd_t q_cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    line_byte,
	output logic          run_last,
	output logic          frame_end
);
	import eft_pkg::*;

`include "escaped_frame_transmitter_core_assert.svh"

	sel_mask_t  mask_q;
	logic [7:0] data_q;
	logic [6:0] acc_q;
	logic       out_valid_q;
	logic [7:0] line_q;
	logic       last_q;
	logic       end_q;

	logic       can_out;
	logic       advance;
	sel_mask_t  rest;
	logic [7:0] sel_byte;
	logic       sel_end;
	logic [6:0] acc_d;

	assign can_out  = !out_valid_q || out_ready;
	assign advance  = (mask_q != '0) && can_out;
	assign rest     = mask_q & (mask_q - 1'b1);
	assign pop      = q_not_empty && ((mask_q == '0) || (advance && (rest == '0)));

	// pick the next line byte and its checksum effect
	always_comb begin
		sel_end = 1'b0;
		priority if (mask_q[SEL_START]) begin
			sel_byte = START_BYTE;
			acc_d    = 7'd1 + START_BYTE[6:0];
		end else if (mask_q[SEL_ESC]) begin
			sel_byte = ESCAPE_BYTE;
			acc_d    = acc_q + 7'd1 + ESCAPE_BYTE[6:0];
		end else if (mask_q[SEL_DATA]) begin
			sel_byte = data_q;
			acc_d    = acc_q + 7'd1 + data_q[6:0];
		end else if (mask_q[SEL_CHK]) begin
			sel_byte = {1'b0, acc_q};
			acc_d    = acc_q;
		end else begin
			sel_byte = END_BYTE;
			sel_end  = 1'b1;
			acc_d    = 7'd0;
		end
	end

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (pop) begin
			mask_q <= q_cmd.mask;
		end else if (advance) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_cmd.data;
		end
	end

	// checksum and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			acc_q       <= acc_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			line_q <= sel_byte;
			last_q <= (rest == '0);
			end_q  <= sel_end;
		end
	end

	assign out_valid = out_valid_q;
	assign line_byte = line_q;
	assign run_last  = last_q;
	assign frame_end = end_q;

	// checks
	`EFT_ASSERT_IMPL(a_end_is_last, out_valid_q && end_q, last_q && (line_q == END_BYTE))
	`EFT_ASSERT_NEXT(a_acc_clear, advance && sel_end, acc_q == 7'd0)
	`EFT_ASSERT_NEXT(a_load_nonempty, pop, mask_q != '0)

endmodule

// ===== sv/escaped_frame_transmitter_core.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_transmitter_core
// Byte-stuffing framer: start byte, escaped payload, 7-bit checksum, end byte.
// ----------------------------------------------------------------------------
// The first line byte of an item passes the command queue and the command register, then the output register.
// One line byte per cycle while the receiver accepts, so an item yields 1 to 5 line bytes
//   (start, escape, data, checksum, end) through the single output byte port.
// A 2-entry command queue lets the input side run ahead of the output side.
// Reset: arst_n clears the queue, frame state, checksum and output valid.
module escaped_frame_transmitter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] payload_byte
	input  logic       s_tlast,   // last_byte
	input  logic       s_tuser,   // empty_packet
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] line_byte
	output logic       m_tlast,   // run_last
	output logic       m_tuser    // frame_end
);
	import eft_pkg::*;

	logic q_full;
	logic q_not_empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	eft_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.payload_byte (s_tdata),
		.last_byte    (s_tlast),
		.empty_packet (s_tuser),
		.q_full       (q_full),
		.in_ready     (s_tready),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	eft_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop_cmd   (pop_cmd)
	);

	eft_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_cmd       (pop_cmd),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.line_byte   (m_tdata),
		.run_last    (m_tlast),
		.frame_end   (m_tuser)
	);

endmodule

// ===== sim/escaped_frame_transmitter_core_tb.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_transmitter_core_tb
// Self-checking bench for the byte-stuffing framer. Payload transfers are fed
// from a queue. A line encoder in the bench predicts each start, escape, data,
// checksum and end byte, and every output transfer is checked against it.
// Directed frames come first, then random frames. Both sides idle at random,
// and the receiver holds off once for a long stretch so that the block fills.
// ----------------------------------------------------------------------------
module escaped_frame_transmitter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import eft_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned IDLE_PCT = 32;
	localparam int unsigned RAND_ITEMS = 110;
	localparam int unsigned LONG_FRAME_LEN = 40;
	localparam int unsigned MAX_PRINTS = 50;

	// one payload transfer
	typedef struct packed {
		logic [7:0] payload;
		logic       last;
		logic       empty;
	} payload_t;

	// one line byte transfer
	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_last;
		logic       frame_end;
	} line_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;  // [7:0] payload_byte
	logic       s_tlast = 1'b0;   // last_byte
	logic       s_tuser = 1'b0;   // empty_packet
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [7:0] line_byte
	logic       m_tlast;          // run_last
	logic       m_tuser;          // frame_end

	payload_t    payload_q[$];
	line_t       line_q[$];

	// encoder state
	logic        frame_open = 1'b0;
	logic [6:0]  check_sum = '0;

	int unsigned items_sent = 0;
	int unsigned lines_seen = 0;
	int unsigned frames_closed = 0;
	int unsigned escapes_sent = 0;
	int unsigned err_count = 0;
	int unsigned cycle_cnt = 0;
	int unsigned hold_cnt = 0;
	logic        hold_done = 1'b0;
	logic        quiet;

	escaped_frame_transmitter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// no idling on either side in this window
	assign quiet = (items_sent >= 70) && (items_sent < 100);

	function automatic line_t mk_line(input logic [7:0] b, input logic is_end);
		mk_line = '{line_byte: b, run_last: 1'b0, frame_end: is_end};
	endfunction

	// checksum counts each byte once plus its value, mod 128
	function automatic void add_to_sum(input logic [7:0] b);
		check_sum = check_sum + 7'd1 + b[6:0];
	endfunction

	// encode one payload transfer into its line bytes
	function automatic void frame_encode(input payload_t it);
		line_t      run [0:4];
		int         n;
		logic [7:0] data;
		n = 0;
		data = it.payload;
		if (!frame_open) begin
			check_sum = '0;
			add_to_sum(START_BYTE);
			run[n] = mk_line(START_BYTE, 1'b0);
			n++;
			frame_open = 1'b1;
		end
		if (!it.empty) begin
			if (data[7]) begin
				add_to_sum(ESCAPE_BYTE);
				run[n] = mk_line(ESCAPE_BYTE, 1'b0);
				n++;
				data = ~data;
				escapes_sent++;
			end
			add_to_sum(data);
			run[n] = mk_line(data, 1'b0);
			n++;
		end
		if (it.empty || it.last) begin
			run[n] = mk_line({1'b0, check_sum}, 1'b0);
			n++;
			run[n] = mk_line(END_BYTE, 1'b1);
			n++;
			frame_open = 1'b0;
			check_sum = '0;
			frames_closed++;
		end
		run[n-1].run_last = 1'b1;
		for (int i = 0; i < n; i++)
			line_q.push_back(run[i]);
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_PRINTS)
			$display("MISMATCH @%0t line byte %0d: %s", $realtime, lines_seen, msg);
		err_count++;
	endtask

	// sender: predict on each accepted transfer, then offer the next item
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				frame_encode('{payload: s_tdata, last: s_tlast, empty: s_tuser});
				items_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (payload_q.size() > 0 &&
				    (quiet || hold_cnt != 0 || $urandom_range(99) >= IDLE_PCT)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= payload_q[0].payload;
					s_tlast  <= payload_q[0].last;
					s_tuser  <= payload_q[0].empty;
					void'(payload_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once, while the sender keeps offering
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
			end else if (!hold_done && items_sent >= 25) begin
				hold_cnt  <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end
		end
	end

	// receiver ready
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_cnt != 0)
			m_tready <= 1'b0;
		else
			m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	// output check against the oldest predicted line byte
	always @(posedge clk) begin
		line_t exp_l;
		if (arst_n && m_tvalid && m_tready) begin
			if (line_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", m_tdata));
			end else begin
				exp_l = line_q.pop_front();
				if (m_tdata !== exp_l.line_byte)
					report_mismatch($sformatf("line_byte %02h, want %02h",
						m_tdata, exp_l.line_byte));
				if (m_tlast !== exp_l.run_last)
					report_mismatch($sformatf("run_last %b, want %b",
						m_tlast, exp_l.run_last));
				if (m_tuser !== exp_l.frame_end)
					report_mismatch($sformatf("frame_end %b, want %b",
						m_tuser, exp_l.frame_end));
			end
			lines_seen++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d line bytes outstanding",
				cycle_cnt, line_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic add_item(input logic [7:0] b, input logic last, input logic empty);
		payload_q.push_back('{payload: b, last: last, empty: empty});
	endtask

	// stimulus and end of run
	initial begin
		int unsigned rand_cnt;
		int unsigned len;
		int unsigned kind;
		logic        long_done;
		logic        close_empty;

		// empty packet with no frame open; ignored fields set on the second
		add_item(8'h00, 1'b0, 1'b1);
		add_item(8'hFF, 1'b1, 1'b1);
		// single-byte frames at the escape boundary
		add_item(8'h00, 1'b1, 1'b0);
		add_item(8'h7F, 1'b1, 1'b0);
		add_item(8'h80, 1'b1, 1'b0);
		add_item(8'hFF, 1'b1, 1'b0);
		// payload equal to the framing bytes
		add_item(START_BYTE, 1'b0, 1'b0);
		add_item(ESCAPE_BYTE, 1'b0, 1'b0);
		add_item(END_BYTE, 1'b0, 1'b0);
		add_item(8'h55, 1'b0, 1'b0);
		add_item(8'hAA, 1'b0, 1'b0);
		add_item(8'h01, 1'b1, 1'b0);
		// open frame closed by an empty packet
		add_item(8'h12, 1'b0, 1'b0);
		add_item(8'h81, 1'b0, 1'b0);
		add_item(8'hA5, 1'b1, 1'b1);
		add_item(8'h7E, 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b1);

		// random frames, one of them long enough to wrap the checksum often
		rand_cnt = 0;
		long_done = 1'b0;
		while (rand_cnt < RAND_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 8) begin
				add_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
				rand_cnt++;
			end else begin
				if (!long_done && rand_cnt > 50) begin
					len = LONG_FRAME_LEN;
					long_done = 1'b1;
				end else begin
					len = $urandom_range(1, 12);
				end
				close_empty = ($urandom_range(99) < 20);
				for (int i = 0; i < len; i++)
					add_item(8'($urandom_range(255)),
						(i == len - 1) && !close_empty, 1'b0);
				rand_cnt += len;
				if (close_empty) begin
					add_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
					rand_cnt++;
				end
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (payload_q.size() != 0 || s_tvalid || line_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d payload transfers in %0d frames; %0d escapes.",
			items_sent, frames_closed, escapes_sent);
		$display("Checked %0d line bytes, %0d mismatches, in %0d cycles.",
			lines_seen, err_count, cycle_cnt);
		if (err_count == 0 && line_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
